>>> hdl/rtk_pkg.sv
// ----------------------------------------------------------------------------
// rtk_pkg
// shared types and widths for the ranked top-k insertion table
// ----------------------------------------------------------------------------
package rtk_pkg;

  localparam int unsigned TagW   = 24;
  localparam int unsigned RoomW  = 16;
  localparam int unsigned MoneyW = 24;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned PlaceW = 7;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [RoomW-1:0]  room;
    logic [MoneyW-1:0] money;
  } entry_t;

  // per-cell compare status handed to the next cell and to the top level
  typedef struct packed {
    logic ge;   // stored entry ranks at or above the candidate
    logic ins;  // candidate lands in this cell
  } cell_stat_t;

endpackage

>>> hdl/rtk_cell.sv
// ----------------------------------------------------------------------------
// rtk_cell
// one table slot: compares its entry with the candidate and either keeps it,
// takes the candidate, or takes its upstream neighbor's entry
// ----------------------------------------------------------------------------
module rtk_cell (
  input  logic               clk_i,
  input  logic               valid_i,     // slot lies below the stored count
  input  logic               upd_i,       // insert beat accepted
  input  rtk_pkg::entry_t    new_i,
  input  rtk_pkg::entry_t    prev_i,
  input  logic               prev_ge_i,
  output rtk_pkg::cell_stat_t stat_o,
  output rtk_pkg::entry_t    entry_o
);

  rtk_pkg::entry_t entry_q;
  rtk_pkg::entry_t entry_d;
  logic            ranks;

  always_comb begin
    if (entry_q.room != new_i.room) begin
      ranks = entry_q.room > new_i.room;
    end else begin
      ranks = entry_q.money >= new_i.money;
    end
  end

  assign stat_o.ge  = valid_i & ranks;
  assign stat_o.ins = ~stat_o.ge & prev_ge_i;

  always_comb begin
    entry_d = entry_q;
    if (upd_i) begin
      if (stat_o.ins) begin
        entry_d = new_i;
      end else if (!stat_o.ge) begin
        entry_d = prev_i;  // shift down behind the insertion point
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> hdl/ranked_top_k_insert_table.sv
// ----------------------------------------------------------------------------
// ranked_top_k_insert_table
// table of up to CAPACITY entries kept in descending (room, money) order,
// built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
//   channel | dir | handshake                 | fields
//   --------+-----+---------------------------+--------------------------------
//   in      | in  | in_valid_i / in_stall_o   | kind, new_tag/room/money, read_index
//   out     | out | out_valid_o / out_stall_i | accepted, place, found, entry_*,
//           |     |                           | stored_count
//
// on every beat all cells compare and shift together, and the result is
// registered, so it shows in the cycle after the input beat.
// a new beat is taken in the cycle the held result leaves, so one beat per
// cycle flows while the output is not stalled.
// reset clears the stored count and the output valid; cell contents are not
// reset and are never shown before they are written.
// ----------------------------------------------------------------------------
module ranked_top_k_insert_table #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [23:0] new_tag_i,
  input  logic [15:0] new_room_i,
  input  logic [23:0] new_money_i,
  input  logic [5:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [6:0]  place_o,
  output logic        found_o,
  output logic [23:0] entry_tag_o,
  output logic [15:0] entry_room_o,
  output logic [23:0] entry_money_o,
  output logic [6:0]  stored_count_o
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic                  in_acc;
  logic                  upd;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       count_d;
  rtk_pkg::entry_t       cand;
  rtk_pkg::entry_t       ent   [CAPACITY];
  rtk_pkg::cell_stat_t   stat  [CAPACITY];
  logic                  any_ins;
  logic [rtk_pkg::PlaceW-1:0] place;
  logic                  hit;
  rtk_pkg::entry_t       rd_ent;

  logic                  out_valid_q;
  logic                  accepted_q;
  logic [rtk_pkg::PlaceW-1:0] place_q;
  logic                  found_q;
  rtk_pkg::entry_t       rd_q;
  logic [rtk_pkg::CountW-1:0] stored_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign upd        = in_acc & (rtk_pkg::kind_e'(kind_i) == rtk_pkg::KIND_INSERT);

  assign cand.tag   = new_tag_i;
  assign cand.room  = new_room_i;
  assign cand.money = new_money_i;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rtk_pkg::entry_t prev;
    logic            prev_ge;
    if (g == 0) begin : g_head
      assign prev    = cand;
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev    = ent[g-1];
      assign prev_ge = stat[g-1].ge;
    end
    rtk_cell u_cell (
      .clk_i     (clk_i),
      .valid_i   (CntW'(g) < count_q),
      .upd_i     (upd),
      .new_i     (cand),
      .prev_i    (prev),
      .prev_ge_i (prev_ge),
      .stat_o    (stat[g]),
      .entry_o   (ent[g])
    );
  end

  // insertion point is one-hot; none set means a full table rejected it
  always_comb begin
    any_ins = 1'b0;
    place   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (stat[i].ins) begin
        any_ins = 1'b1;
        place   = place | rtk_pkg::PlaceW'(i);
      end
    end
    if (!any_ins) begin
      place = rtk_pkg::PlaceW'(CAPACITY);
    end
  end

  assign hit    = {1'b0, read_index_i} < rtk_pkg::PlaceW'(count_q);
  assign rd_ent = hit ? ent[read_index_i[SlotW-1:0]] : '0;

  always_comb begin
    count_d = count_q;
    if (upd && any_ins && (count_q < CntW'(CAPACITY))) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (rtk_pkg::kind_e'(kind_i) == rtk_pkg::KIND_INSERT) begin
        accepted_q <= any_ins;
        place_q    <= place;
        found_q    <= 1'b0;
        rd_q       <= '0;
      end else begin
        accepted_q <= 1'b0;
        place_q    <= '0;
        found_q    <= hit;
        rd_q       <= rd_ent;
      end
      stored_q <= rtk_pkg::CountW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = accepted_q;
  assign place_o        = place_q;
  assign found_o        = found_q;
  assign entry_tag_o    = rd_q.tag;
  assign entry_room_o   = rd_q.room;
  assign entry_money_o  = rd_q.money;
  assign stored_count_o = stored_q;

endmodule
